[design/eden_pkg.sv]
// Shared constants, types and request codes for the edit distance engine.
// No dependencies; imported by eden_cell_unit and edit_distance_engine_core.

package eden_pkg;

    localparam int MAX_LEN     = 1024;
    localparam int SYMBOL_BITS = 8;

    // Field widths fixed by the item format
    localparam int REQ_W  = 2;
    localparam int SYM_W  = 8;
    localparam int DIST_W = 11;

    // Counts and costs run 0..MAX_LEN
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int STR_AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    localparam logic [REQ_W-1:0] REQ_APPEND_FIRST  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND_SECOND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COMPUTE       = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW_RD,
        ST_ROW_SET,
        ST_CELL_RD,
        ST_CELL_WR,
        ST_EMIT
    } state_t;

    // Operands of one table cell update
    typedef struct packed {
        logic [SYMBOL_BITS-1:0] sym_a;
        logic [SYMBOL_BITS-1:0] sym_b;
        logic [LEN_W-1:0]       up;
        logic [LEN_W-1:0]       left;
        logic [LEN_W-1:0]       diag;
    } cell_ops_t;

endpackage

[design/eden_cell_unit.sv]
// Cell update unit: compare, three-way minimum and increment for one DP cell.
// Depends on eden_pkg.

module eden_cell_unit
    import eden_pkg::*;
(
    input  cell_ops_t        ops,
    output logic [LEN_W-1:0] val
);

    logic [LEN_W-1:0] min_ul;
    logic [LEN_W-1:0] min_all;

    always_comb
    begin
        min_ul  = (ops.up < ops.left) ? ops.up : ops.left;
        min_all = (min_ul < ops.diag) ? min_ul : ops.diag;
        if (ops.sym_a == ops.sym_b)
        begin
            val = ops.diag;
        end
        else
        begin
            val = min_all + LEN_W'(1);
        end
    end

endmodule

[design/edit_distance_engine_core.sv]
// Levenshtein edit distance engine: string stores, row buffer and DP sequencer.
// Depends on eden_pkg and eden_cell_unit.
//
//  port group   dir  handshake               payload
//  request      in   start && !busy          req_type[1:0], symbol[7:0]
//  result       out  done (one-cycle strobe) distance[10:0], too_long
//
// An append leaves busy low, so appends can arrive every cycle while idle.
// A compute holds busy until its result, an and bn being the string lengths:
// one row buffer write per cycle seeds the bottom row, then each row takes a
// read and a set-up step and each cell a read and a write step, paced by the
// registered row buffer read. done pulses in the cycle busy falls. Reset clears
// lengths, flags and sequencer, not the memories. Results cannot be stalled.

module edit_distance_engine_core
    import eden_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [SYM_W-1:0]  symbol,
    output logic              done,
    output logic [DIST_W-1:0] distance,
    output logic              too_long
);

    // Memories
    logic [SYMBOL_BITS-1:0] first_mem  [MAX_LEN];
    logic [SYMBOL_BITS-1:0] second_mem [MAX_LEN];
    logic [LEN_W-1:0]       row_mem    [MAX_LEN + 1];

    logic [SYMBOL_BITS-1:0] first_q;
    logic [SYMBOL_BITS-1:0] second_q;
    logic [LEN_W-1:0]       row_q;

    logic                   first_we;
    logic [STR_AW-1:0]      first_wa;
    logic [STR_AW-1:0]      first_ra;
    logic                   second_we;
    logic [STR_AW-1:0]      second_wa;
    logic [STR_AW-1:0]      second_ra;
    logic                   row_we;
    logic [LEN_W-1:0]       row_wa;
    logic [LEN_W-1:0]       row_wd;
    logic [LEN_W-1:0]       row_ra;

    // Control state
    state_t           state_reg, state_next;
    logic [LEN_W-1:0] first_len_reg, first_len_next;
    logic [LEN_W-1:0] second_len_reg, second_len_next;
    logic             ovf_reg, ovf_next;
    logic [LEN_W-1:0] an_reg, an_next;
    logic [LEN_W-1:0] bn_reg, bn_next;
    logic [LEN_W-1:0] i_reg, i_next;
    logic [LEN_W-1:0] j_reg, j_next;
    logic             done_reg, done_next;

    // Payload
    logic [LEN_W-1:0]  diag_reg, diag_next;
    logic [LEN_W-1:0]  left_reg, left_next;
    logic [LEN_W-1:0]  result_reg, result_next;
    logic [DIST_W-1:0] distance_reg, distance_next;
    logic              too_long_reg, too_long_next;

    logic [LEN_W-1:0]       i_m1;
    logic [LEN_W-1:0]       j_m1;
    logic [SYMBOL_BITS-1:0] sym_in;
    cell_ops_t              cell_ops;
    logic [LEN_W-1:0]       cell_val;

    assign i_m1   = i_reg - LEN_W'(1);
    assign j_m1   = j_reg - LEN_W'(1);
    assign sym_in = symbol[SYMBOL_BITS-1:0];

    assign cell_ops.sym_a = first_q;
    assign cell_ops.sym_b = second_q;
    assign cell_ops.up    = row_q;
    assign cell_ops.left  = left_reg;
    assign cell_ops.diag  = diag_reg;

    eden_cell_unit u_cell
    (
        .ops (cell_ops),
        .val (cell_val)
    );

    always_comb
    begin
        state_next      = state_reg;
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        ovf_next        = ovf_reg;
        an_next         = an_reg;
        bn_next         = bn_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        done_next       = 1'b0;
        diag_next       = diag_reg;
        left_next       = left_reg;
        result_next     = result_reg;
        distance_next   = distance_reg;
        too_long_next   = too_long_reg;

        first_we  = 1'b0;
        first_wa  = first_len_reg[STR_AW-1:0];
        first_ra  = i_m1[STR_AW-1:0];
        second_we = 1'b0;
        second_wa = second_len_reg[STR_AW-1:0];
        second_ra = j_m1[STR_AW-1:0];
        row_we    = 1'b0;
        row_wa    = j_reg;
        row_wd    = bn_reg - j_reg;
        row_ra    = j_m1;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        REQ_APPEND_FIRST:
                        begin
                            if (first_len_reg < LEN_W'(MAX_LEN))
                            begin
                                first_we       = 1'b1;
                                first_len_next = first_len_reg + LEN_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        REQ_APPEND_SECOND:
                        begin
                            if (second_len_reg < LEN_W'(MAX_LEN))
                            begin
                                second_we       = 1'b1;
                                second_len_next = second_len_reg + LEN_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        REQ_COMPUTE:
                        begin
                            an_next    = first_len_reg;
                            bn_next    = second_len_reg;
                            j_next     = '0;
                            state_next = ST_INIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Bottom row: row[j] = bn - j
            ST_INIT:
            begin
                row_we = 1'b1;
                row_wa = j_reg;
                row_wd = bn_reg - j_reg;
                j_next = j_reg + LEN_W'(1);
                if (j_reg == bn_reg)
                begin
                    i_next     = an_reg;
                    state_next = (an_reg == '0) ? ST_EMIT : ST_ROW_RD;
                end
            end

            ST_ROW_RD:
            begin
                first_ra   = i_m1[STR_AW-1:0];
                row_ra     = bn_reg;
                state_next = ST_ROW_SET;
            end

            ST_ROW_SET:
            begin
                row_we    = 1'b1;
                row_wa    = bn_reg;
                row_wd    = an_reg - i_m1;
                diag_next = row_q;
                left_next = an_reg - i_m1;
                j_next    = bn_reg;
                if (bn_reg == '0)
                begin
                    i_next     = i_m1;
                    state_next = (i_reg == LEN_W'(1)) ? ST_EMIT : ST_ROW_RD;
                end
                else
                begin
                    state_next = ST_CELL_RD;
                end
            end

            ST_CELL_RD:
            begin
                row_ra     = j_m1;
                second_ra  = j_m1[STR_AW-1:0];
                state_next = ST_CELL_WR;
            end

            ST_CELL_WR:
            begin
                row_we    = 1'b1;
                row_wa    = j_m1;
                row_wd    = cell_val;
                left_next = cell_val;
                diag_next = row_q;
                j_next    = j_m1;
                if (j_reg == LEN_W'(1))
                begin
                    i_next     = i_m1;
                    state_next = (i_reg == LEN_W'(1)) ? ST_EMIT : ST_ROW_RD;
                end
                else
                begin
                    state_next = ST_CELL_RD;
                end
            end

            ST_EMIT:
            begin
                done_next       = 1'b1;
                distance_next   = DIST_W'(result_reg);
                too_long_next   = ovf_reg;
                first_len_next  = '0;
                second_len_next = '0;
                ovf_next        = 1'b0;
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // The distance is whatever last lands in row[0]
        if (row_we && (row_wa == '0))
        begin
            result_next = row_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            ovf_reg        <= 1'b0;
            an_reg         <= '0;
            bn_reg         <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            ovf_reg        <= ovf_next;
            an_reg         <= an_next;
            bn_reg         <= bn_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diag_reg     <= diag_next;
        left_reg     <= left_next;
        result_reg   <= result_next;
        distance_reg <= distance_next;
        too_long_reg <= too_long_next;
    end

    always_ff @(posedge clk)
    begin
        if (first_we)
        begin
            first_mem[first_wa] <= sym_in;
        end
        first_q <= first_mem[first_ra];
    end

    always_ff @(posedge clk)
    begin
        if (second_we)
        begin
            second_mem[second_wa] <= sym_in;
        end
        second_q <= second_mem[second_ra];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_wa] <= row_wd;
        end
        row_q <= row_mem[row_ra];
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign distance = distance_reg;
    assign too_long = too_long_reg;

    // Checks

    a_done_after_emit : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_EMIT))
        else $error("result strobe without a preceding emit step");

    a_compute_goes_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_COMPUTE)) |=> busy)
        else $error("compute request did not start the sequencer");

    a_len_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        (first_len_reg <= LEN_W'(MAX_LEN)) && (second_len_reg <= LEN_W'(MAX_LEN)))
        else $error("string length beyond capacity");

    a_cell_column_valid : assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_CELL_RD) || (state_reg == ST_CELL_WR)) |->
            ((j_reg != '0) && (j_reg <= bn_reg)))
        else $error("cell column index out of range");

endmodule
